/* hw/rtl/dps_pkg.sv */
// Shared types and constants for the decimal pattern scanner.
package dps_pkg;

    localparam int FMT_MAX     = 16;
    localparam int FMT_STORE   = 16;
    localparam int FMT_BYTES   = (FMT_MAX < FMT_STORE) ? FMT_MAX : FMT_STORE;
    localparam int FMT_IDX_W   = $clog2(FMT_STORE);
    localparam int POS_W       = 5;
    localparam int VAL_W       = 64;
    localparam int NUM_SLOTS   = 3;
    localparam int OUT_RAW_W   = 2 + NUM_SLOTS * VAL_W;
    localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_DONE    = 5'd31;
    localparam logic [POS_W-1:0] FMT_LEN_CAP = 5'(FMT_BYTES);

    localparam logic [1:0] REG_FMT_LOW  = 2'd0;
    localparam logic [1:0] REG_FMT_HIGH = 2'd1;
    localparam logic [1:0] REG_FMT_LEN  = 2'd2;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [1:0] FIELDS_MAX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] slot;
        logic [3:0] digit;
        logic       emit;
        logic [1:0] count;
    } acc_cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* hw/rtl/dps_fmt.sv */
// Format register file with byte lookup and token pattern flags.
module dps_fmt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic [dps_pkg::POS_W-1:0]     pos,
    output logic [7:0]                    fmt_byte,
    output logic                          fmt_llu
);

    logic [63:0]                fmt_low_reg;
    logic [63:0]                fmt_high_reg;
    logic [dps_pkg::POS_W-1:0]  fmt_len_reg;
    logic [dps_pkg::POS_W-1:0]  eff_len;
    logic [7:0]                 fmt_bytes [dps_pkg::FMT_STORE];
    logic [dps_pkg::FMT_STORE-1:0] llu_flags;
    logic                       wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_low_reg  <= '0;
            fmt_high_reg <= '0;
            fmt_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                dps_pkg::REG_FMT_LOW:  fmt_low_reg  <= cfg_data;
                dps_pkg::REG_FMT_HIGH: fmt_high_reg <= cfg_data;
                dps_pkg::REG_FMT_LEN:  fmt_len_reg  <= cfg_data[dps_pkg::POS_W-1:0];
                default:               ;
            endcase
        end
    end

    assign eff_len = (fmt_len_reg > dps_pkg::FMT_LEN_CAP) ? dps_pkg::FMT_LEN_CAP : fmt_len_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            fmt_bytes[i]     = fmt_low_reg[8*i +: 8];
            fmt_bytes[i + 8] = fmt_high_reg[8*i +: 8];
        end
    end

    always_comb
    begin
        for (int p = 0; p < dps_pkg::FMT_STORE; p++)
        begin
            if (p + 3 < dps_pkg::FMT_STORE)
            begin
                llu_flags[p] = (6'(p + 3) < {1'b0, eff_len})
                             && (fmt_bytes[p + 1] == dps_pkg::CH_L)
                             && (fmt_bytes[p + 2] == dps_pkg::CH_L)
                             && (fmt_bytes[p + 3] == dps_pkg::CH_U);
            end
            else
            begin
                llu_flags[p] = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (pos < eff_len)
        begin
            fmt_byte = fmt_bytes[pos[dps_pkg::FMT_IDX_W-1:0]];
            fmt_llu  = llu_flags[pos[dps_pkg::FMT_IDX_W-1:0]];
        end
        else
        begin
            fmt_byte = dps_pkg::CH_NUL;
            fmt_llu  = 1'b0;
        end
    end

endmodule

/* hw/rtl/dps_acc.sv */
// Value slots, shared multiply-by-ten-and-add unit and result register.
module dps_acc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dps_pkg::acc_cmd_t          cmd,
    output logic                       out_free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dps_pkg::OUT_W-1:0]  m_tdata
);

    logic [dps_pkg::VAL_W-1:0] slot_reg [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::VAL_W-1:0] base;
    logic [dps_pkg::VAL_W-1:0] mac;
    logic [dps_pkg::VAL_W-1:0] shown [dps_pkg::NUM_SLOTS];
    logic                      out_valid_reg;
    logic [dps_pkg::OUT_W-1:0] out_data_reg;
    logic [dps_pkg::OUT_W-1:0] out_data_next;

    assign base = cmd.start ? '0 : slot_reg[cmd.slot];
    assign mac  = (base << 3) + (base << 1) + dps_pkg::VAL_W'(cmd.digit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dps_pkg::NUM_SLOTS; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else if (cmd.emit)
        begin
            for (int k = 0; k < dps_pkg::NUM_SLOTS; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else if (cmd.load && (cmd.slot != dps_pkg::FIELDS_MAX))
        begin
            slot_reg[cmd.slot] <= mac;
        end
    end

    always_comb
    begin
        for (int k = 0; k < dps_pkg::NUM_SLOTS; k++)
        begin
            shown[k] = (2'(k) < cmd.count) ? slot_reg[k] : '0;
        end
        out_data_next = {(dps_pkg::OUT_W - dps_pkg::OUT_RAW_W)'(0),
                         shown[2], shown[1], shown[0], cmd.count};
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/dps_ctrl.sv */
// Scan sequencer: walks the format one element per cycle for each item.
module dps_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       s_tlast,
    output logic [dps_pkg::POS_W-1:0]  pos,
    input  logic [7:0]                 fmt_byte,
    input  logic                       fmt_llu,
    input  logic                       out_free,
    output dps_pkg::acc_cmd_t          cmd
);

    dps_pkg::state_t            state_reg, state_next;
    logic [7:0]                 char_reg, char_next;
    logic [dps_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       in_num_reg, in_num_next;
    logic                       failed_reg, failed_next;
    logic [1:0]                 fields_reg, fields_next;

    logic                       accept;
    logic                       c_dig;
    logic                       c_ws;
    logic [3:0]                 c_val;
    logic [1:0]                 fields_inc;
    logic [2:0]                 count_sum;
    logic [1:0]                 count;
    logic                       step_done;

    assign s_tready   = (state_reg == dps_pkg::ST_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign pos        = pos_reg;
    assign c_dig      = dps_pkg::is_digit(char_reg);
    assign c_ws       = dps_pkg::is_ws(char_reg);
    assign c_val      = 4'(char_reg - dps_pkg::CH_ZERO);
    assign fields_inc = (fields_reg != dps_pkg::FIELDS_MAX) ? fields_reg + 2'd1 : fields_reg;
    assign count_sum  = {1'b0, fields_reg} + {2'b0, in_num_reg};
    assign count      = failed_reg ? 2'd0
                      : ((count_sum > 3'd3) ? dps_pkg::FIELDS_MAX : count_sum[1:0]);

    always_comb
    begin
        if (in_num_reg)
        begin
            step_done = c_dig;
        end
        else if (fmt_byte == dps_pkg::CH_NUL)
        begin
            step_done = 1'b1;
        end
        else if (dps_pkg::is_ws(fmt_byte))
        begin
            step_done = c_ws;
        end
        else
        begin
            step_done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dps_pkg::ST_IDLE;
            pos_reg    <= '0;
            in_num_reg <= 1'b0;
            failed_reg <= 1'b0;
            fields_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            in_num_reg <= in_num_next;
            failed_reg <= failed_next;
            fields_reg <= fields_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        state_next = dps_pkg::ST_EMIT;
                    end
                    else if (!failed_reg && (s_tdata != dps_pkg::CH_NUL))
                    begin
                        state_next = dps_pkg::ST_STEP;
                    end
                end
            end
            dps_pkg::ST_STEP:
            begin
                if (step_done)
                begin
                    state_next = dps_pkg::ST_IDLE;
                end
            end
            dps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = dps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        char_next   = char_reg;
        pos_next    = pos_reg;
        in_num_next = in_num_reg;
        failed_next = failed_reg;
        fields_next = fields_reg;
        cmd         = '0;
        cmd.slot    = fields_reg;
        cmd.digit   = c_val;
        cmd.count   = count;
        unique case (state_reg)
            dps_pkg::ST_IDLE:
            begin
                if (accept && !s_tlast && !failed_reg)
                begin
                    char_next = s_tdata;
                    if (s_tdata == dps_pkg::CH_NUL)
                    begin
                        if (in_num_reg)
                        begin
                            in_num_next = 1'b0;
                            fields_next = fields_inc;
                        end
                        pos_next = dps_pkg::POS_DONE;
                    end
                end
            end
            dps_pkg::ST_STEP:
            begin
                if (in_num_reg)
                begin
                    if (c_dig)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        in_num_next = 1'b0;
                        fields_next = fields_inc;
                    end
                end
                else if (fmt_byte == dps_pkg::CH_NUL)
                begin
                    pos_next = pos_reg;
                end
                else if (dps_pkg::is_ws(fmt_byte))
                begin
                    if (!c_ws)
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                else if (fmt_byte == dps_pkg::CH_PCT)
                begin
                    if (!fmt_llu || (fields_reg == dps_pkg::FIELDS_MAX) || !c_dig)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load    = 1'b1;
                        cmd.start   = 1'b1;
                        in_num_next = 1'b1;
                        pos_next    = pos_reg + 5'd4;
                    end
                end
                else if (char_reg != fmt_byte)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            dps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit    = 1'b1;
                    pos_next    = '0;
                    in_num_next = 1'b0;
                    failed_next = 1'b0;
                    fields_next = '0;
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

endmodule

/* hw/rtl/decimal_pattern_scanner.sv */
// Top level of the decimal pattern scanner.
//
//  Channel   Signals                                  Direction  Item
//  s_*       s_tvalid s_tready s_tdata[7:0] s_tlast   in         one character or end mark
//  m_*       m_tvalid m_tready m_tdata[199:0]         out        count and three values
//  cfg_*     cfg_valid cfg_ready cfg_index cfg_data   in         format register write
//
//  A character is accepted in ST_IDLE, then ST_STEP visits the format elements it needs
//  (whitespace skips and closing a number each add a visit) before returning to ST_IDLE.
//  A zero character, or any character after a failure, is taken in ST_IDLE alone.
//  An end item goes through ST_EMIT, waiting there while m_tready is low and a result is held.
//  Characters keep flowing while a result waits in the output register.
//  rst_n clears the format registers, the scan state and the output valid.
module decimal_pattern_scanner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] char_in
    input  logic                       s_tlast,   // end_of_input
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dps_pkg::OUT_W-1:0]  m_tdata,   // [1:0] match_count, [65:2] value_first,
                                                  // [129:66] value_second,
                                                  // [193:130] value_third, [199:194] zero
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [63:0]                cfg_data
);

    logic [dps_pkg::POS_W-1:0] pos;
    logic [7:0]                fmt_byte;
    logic                      fmt_llu;
    logic                      out_free;
    dps_pkg::acc_cmd_t         cmd;

    dps_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos       (pos),
        .fmt_byte  (fmt_byte),
        .fmt_llu   (fmt_llu)
    );

    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .pos      (pos),
        .fmt_byte (fmt_byte),
        .fmt_llu  (fmt_llu),
        .out_free (out_free),
        .cmd      (cmd)
    );

    dps_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/tb_decimal_pattern_scanner.sv */
// Self-checking testbench for the decimal pattern scanner: directed table, then random scans.
`timescale 1ns / 1ps

module tb_decimal_pattern_scanner;

    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 50;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]                count;
        logic [dps_pkg::VAL_W-1:0] v0;
        logic [dps_pkg::VAL_W-1:0] v1;
        logic [dps_pkg::VAL_W-1:0] v2;
    } scan_result_t;

    typedef enum logic [1:0] {RK_CHAR, RK_END, RK_FMT} row_kind_t;
    typedef enum logic [1:0] {EL_BLANK, EL_LIT, EL_NUM} elem_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [7:0]   ch;
        logic         pinned;
        logic [127:0] fmt;
        logic [4:0]   fmt_len;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dps_pkg::OUT_W-1:0]     m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = '0;
    logic [63:0]                   cfg_data = '0;

    logic [63:0]                   pat_lo = '0;
    logic [63:0]                   pat_hi = '0;
    logic [4:0]                    pat_len = '0;
    logic [dps_pkg::POS_W-1:0]     cur_pos;
    logic                          num_open;
    logic                          scan_bad;
    logic [1:0]                    fields_cnt;
    logic [dps_pkg::VAL_W-1:0]     acc [dps_pkg::NUM_SLOTS];

    scan_result_t         pending_scans[$];
    scan_result_t         got_res;
    scan_result_t         want_res;
    stim_row_t            plan[$];
    elem_kind_t           el_kind[$];
    logic [7:0]           el_char[$];
    logic [7:0]           line_q[$];

    int                   n_items = 0;
    int                   n_results = 0;
    int                   n_formats = 0;
    int                   n_full = 0;
    int                   n_part = 0;
    int                   n_zero = 0;
    int                   n_fail = 0;
    int                   cycles = 0;
    int                   rx_wait = 0;
    logic                 rx_hold = 1'b0;
    bit                   calm = 1'b0;

    decimal_pattern_scanner DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == dps_pkg::CH_SP) || (c >= dps_pkg::CH_TAB && c <= dps_pkg::CH_CR);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= dps_pkg::CH_ZERO) && (c <= dps_pkg::CH_NINE);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? dps_pkg::CH_SP : dps_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic int eff_len();
        return (int'(pat_len) > dps_pkg::FMT_BYTES) ? dps_pkg::FMT_BYTES : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_char(input int p);
        if (p >= eff_len())
            return dps_pkg::CH_NUL;
        if (p < 8)
            return pat_lo[8*p +: 8];
        return pat_hi[8*(p-8) +: 8];
    endfunction

    function automatic void clear_scan();
        cur_pos = '0;
        num_open = 1'b0;
        scan_bad = 1'b0;
        fields_cnt = '0;
        for (int i = 0; i < dps_pkg::NUM_SLOTS; i++)
            acc[i] = '0;
    endfunction

    function automatic void close_field();
        if (num_open)
        begin
            num_open = 1'b0;
            if (fields_cnt < dps_pkg::FIELDS_MAX)
                fields_cnt++;
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [7:0] f;
        for (int g = 0; g < 40; g++)
        begin
            if (num_open)
            begin
                if (is_numeral(c))
                begin
                    if (fields_cnt < dps_pkg::FIELDS_MAX)
                        acc[fields_cnt] = acc[fields_cnt] * 64'd10
                                        + 64'(c - dps_pkg::CH_ZERO);
                    return;
                end
                close_field();
                continue;
            end
            f = pat_char(int'(cur_pos));
            if (f == dps_pkg::CH_NUL)
                return;
            if (is_blank(f))
            begin
                if (is_blank(c))
                    return;
                cur_pos++;
                continue;
            end
            if (f == dps_pkg::CH_PCT)
            begin
                if (pat_char(int'(cur_pos) + 1) != dps_pkg::CH_L ||
                    pat_char(int'(cur_pos) + 2) != dps_pkg::CH_L ||
                    pat_char(int'(cur_pos) + 3) != dps_pkg::CH_U ||
                    fields_cnt >= dps_pkg::FIELDS_MAX || !is_numeral(c))
                begin
                    scan_bad = 1'b1;
                    return;
                end
                acc[fields_cnt] = 64'(c - dps_pkg::CH_ZERO);
                num_open = 1'b1;
                cur_pos += 4;
                return;
            end
            if (c != f)
            begin
                scan_bad = 1'b1;
                return;
            end
            cur_pos++;
            return;
        end
    endfunction

    function automatic void scan_model_step(input logic [7:0] c, input logic last,
                                            output bit has, output scan_result_t res);
        int cnt;
        has = 1'b0;
        res = '0;
        if (last)
        begin
            cnt = scan_bad ? 0 : int'(fields_cnt) + int'(num_open);
            if (cnt > 3)
                cnt = 3;
            res.count = cnt[1:0];
            if (cnt >= 1)
                res.v0 = acc[0];
            if (cnt >= 2)
                res.v1 = acc[1];
            if (cnt >= 3)
                res.v2 = acc[2];
            has = 1'b1;
            clear_scan();
            return;
        end
        if (scan_bad)
            return;
        if (c == dps_pkg::CH_NUL)
        begin
            close_field();
            cur_pos = dps_pkg::POS_DONE;
            return;
        end
        scan_char(c);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%016h, got 0x%016h", $time, name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void plan_byte(input logic [7:0] c);
        stim_row_t row;
        row = '0;
        row.kind = RK_CHAR;
        row.ch = c;
        plan.push_back(row);
    endfunction

    function automatic void plan_text(input string s);
        for (int i = 0; i < s.len(); i++)
            plan_byte(s[i]);
    endfunction

    function automatic void plan_end(input logic pinned);
        stim_row_t row;
        row = '0;
        row.kind = RK_END;
        row.pinned = pinned;
        plan.push_back(row);
    endfunction

    function automatic void plan_format(input string s, input int len);
        stim_row_t row;
        row = '0;
        row.kind = RK_FMT;
        for (int i = 0; i < s.len() && i < dps_pkg::FMT_BYTES; i++)
            row.fmt[8*i +: 8] = s[i];
        row.fmt_len = 5'(len);
        plan.push_back(row);
    endfunction

    function automatic void build_format(output logic [127:0] img, output logic [4:0] len);
        int n;
        int r;
        img = '0;
        n = 0;
        repeat ($urandom_range(1, 8))
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                if (n <= dps_pkg::FMT_BYTES - 4)
                begin
                    img[8*n +: 32] = {dps_pkg::CH_U, dps_pkg::CH_L, dps_pkg::CH_L,
                                      dps_pkg::CH_PCT};
                    n += 4;
                end
            end
            else if (n < dps_pkg::FMT_BYTES)
            begin
                if (r < 60)
                    img[8*n +: 8] = pick_blank();
                else if (r < 93)
                begin
                    r = $urandom_range(33, 126);
                    img[8*n +: 8] = (r == dps_pkg::CH_PCT) ? dps_pkg::CH_L : 8'(r);
                end
                else if (r < 97)
                    img[8*n +: 8] = dps_pkg::CH_PCT;
                else
                    img[8*n +: 8] = dps_pkg::CH_NUL;
                n++;
            end
        end
        r = $urandom_range(0, 99);
        len = (r < 70) ? 5'(n)
            : (r < 85) ? 5'($urandom_range(0, dps_pkg::FMT_BYTES))
            : 5'(dps_pkg::FMT_BYTES);
    endfunction

    function automatic void parse_format();
        int p;
        logic [7:0] b;
        el_kind.delete();
        el_char.delete();
        p = 0;
        while (p < eff_len())
        begin
            b = pat_char(p);
            if (b == dps_pkg::CH_PCT && pat_char(p + 1) == dps_pkg::CH_L &&
                pat_char(p + 2) == dps_pkg::CH_L && pat_char(p + 3) == dps_pkg::CH_U)
            begin
                el_kind.push_back(EL_NUM);
                el_char.push_back(b);
                p += 4;
            end
            else
            begin
                el_kind.push_back(is_blank(b) ? EL_BLANK : EL_LIT);
                el_char.push_back(b);
                p++;
            end
        end
    endfunction

    function automatic void make_line();
        int r;
        int k;
        line_q.delete();
        r = $urandom_range(0, 99);
        if (r >= 88 || el_kind.size() == 0)
        begin
            repeat ($urandom_range(1, 12))
                line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        foreach (el_kind[i])
        begin
            case (el_kind[i])
                EL_BLANK:
                    repeat ($urandom_range(0, 2))
                        line_q.push_back(pick_blank());
                EL_LIT:
                    line_q.push_back(el_char[i]);
                EL_NUM:
                begin
                    k = $urandom_range(0, 99);
                    k = (k < 80) ? $urandom_range(1, 4) :
                        (k < 94) ? $urandom_range(5, 18) : $urandom_range(19, 22);
                    repeat (k)
                        line_q.push_back(dps_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                end
                default: ;
            endcase
        end
        if ($urandom_range(0, 99) < 12)
        begin
            k = $urandom_range(0, line_q.size());
            while (line_q.size() > k)
                void'(line_q.pop_back());
        end
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3))
                line_q.push_back(8'($urandom_range(1, 255)));
        if (r >= 70 && line_q.size() != 0)
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input logic [7:0] c, input logic last, input logic pinned);
        int gap;
        bit has;
        scan_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        n_items++;
        scan_model_step(c, last, has, res);
        if (has)
            pending_scans.push_back(pinned ? scan_result_t'(0) : res);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            dps_pkg::REG_FMT_LOW:  pat_lo = d;
            dps_pkg::REG_FMT_HIGH: pat_hi = d;
            dps_pkg::REG_FMT_LEN:  pat_len = d[4:0];
            default: ;
        endcase
    endtask

    task automatic load_format(input logic [127:0] img, input logic [4:0] len);
        s_tvalid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        put_reg(dps_pkg::REG_FMT_LOW, img[63:0]);
        put_reg(dps_pkg::REG_FMT_HIGH, img[127:64]);
        put_reg(dps_pkg::REG_FMT_LEN, {59'd0, len});
        cfg_valid <= 1'b0;
        n_formats++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("** decimal_pattern_scanner: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_wait <= pick_gap();
        end
    end

    // hold off the result side long enough to back up the input
    initial
    begin
        wait (n_items >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res.count = m_tdata[1:0];
            got_res.v0 = m_tdata[2 +: dps_pkg::VAL_W];
            got_res.v1 = m_tdata[2 + dps_pkg::VAL_W +: dps_pkg::VAL_W];
            got_res.v2 = m_tdata[2 + 2*dps_pkg::VAL_W +: dps_pkg::VAL_W];
            n_results++;
            if (pending_scans.size() == 0)
            begin
                $display("%0t: result with no scan pending, match_count %0d",
                         $time, got_res.count);
                n_fail++;
            end
            else
            begin
                want_res = pending_scans.pop_front();
                check_field("match_count", 64'(want_res.count), 64'(got_res.count));
                check_field("value_first", want_res.v0, got_res.v0);
                check_field("value_second", want_res.v1, got_res.v1);
                check_field("value_third", want_res.v2, got_res.v2);
                if (want_res.count == 2'd3)
                    n_full++;
                else if (want_res.count == 2'd0)
                    n_zero++;
                else
                    n_part++;
            end
        end
    end

    initial
    begin
        int nseq;
        int ph;
        int r;
        logic [127:0] img;
        logic [4:0] len;

        clear_scan();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_byte(8'hFF);
        plan_end(1'b1);
        plan_format("%llu %llu,%llu", 14);
        plan_text("12 \t3,4");
        plan_end(1'b0);
        plan_text("9x");
        plan_end(1'b1);
        plan_text("5");
        plan_byte(dps_pkg::CH_NUL);
        plan_text("6");
        plan_end(1'b0);
        plan_format("a%lu", 4);
        plan_text("a1");
        plan_end(1'b1);
        plan_format("<%llu", 5);
        plan_text("<42z");
        plan_end(1'b0);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                RK_FMT:  load_format(plan[i].fmt, plan[i].fmt_len);
                RK_CHAR: push_item(plan[i].ch, 1'b0, 1'b0);
                RK_END:  push_item(8'($urandom_range(0, 255)), 1'b1, plan[i].pinned);
                default: ;
            endcase
        end

        ph = 0;
        while (n_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (ph == 0)
            begin
                img = '1;
                len = 5'(dps_pkg::FMT_BYTES);
            end
            else if (ph == 1)
            begin
                img = {$urandom, $urandom, $urandom, $urandom};
                len = '0;
            end
            else if (r < 15)
            begin
                img = {$urandom, $urandom, $urandom, $urandom};
                len = 5'($urandom_range(0, dps_pkg::FMT_BYTES));
            end
            else
                build_format(img, len);
            load_format(img, len);
            parse_format();
            calm = ($urandom_range(0, 3) == 0);
            nseq = $urandom_range(4, 12);
            repeat (nseq)
            begin
                make_line();
                foreach (line_q[i])
                    push_item(line_q[i], 1'b0, 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            ph++;
        end

        s_tvalid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Scanned %0d characters and end marks under %0d format settings, %0d results.",
                 n_items, n_formats, n_results);
        $display("Scans with three fields: %0d, with one or two: %0d, with none: %0d.",
                 n_full, n_part, n_zero);
        if (n_fail == 0)
            $display("** decimal_pattern_scanner: PASSED **");
        else
            $display("** decimal_pattern_scanner: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/dps_pkg.sv
hw/rtl/dps_fmt.sv
hw/rtl/dps_acc.sv
hw/rtl/dps_ctrl.sv
hw/rtl/decimal_pattern_scanner.sv
tb/tb_decimal_pattern_scanner.sv
